// ===== rtl/wpgc_pkg.sv =====
`default_nettype none
package wpgc_pkg;

	localparam int unsigned ACT_W = 2;
	localparam int unsigned IDX_W = 11;
	localparam int unsigned VAL_W = 12;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned BYTE_W = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD_RS = 2'd0,
		ACT_LOAD_NL = 2'd1,
		ACT_START   = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [0:0] {
		KIND_REPORT = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_RESP,
		S_SWEEP,
		S_CHK_RD,
		S_CHK_CK,
		S_NL_RD,
		S_NL_CK,
		S_SCAN_RD,
		S_SCAN_CK,
		S_PICK,
		S_COL_VO,
		S_COL_U,
		S_COL_LO,
		S_COL_HI,
		S_NB_RD,
		S_NB_CL,
		S_NB_MK,
		S_SR_RD,
		S_SR_CK,
		S_ASSIGN,
		S_BAD,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic sweep;
		logic rs_rd;
		logic rs_ck;
		logic nl_rd;
		logic nl_ck;
		logic sort_init;
		logic scan_rd;
		logic scan_ck;
		logic pick;
		logic col_init;
		logic vo_rd;
		logic u_rd;
		logic lo_rd;
		logic hi_cap;
		logic nb_cl;
		logic nb_mk;
		logic sr_init;
		logic sr_rd;
		logic sr_ck;
		logic assign_c;
		logic bad;
		logic report;
		logic rd_resp;
	} cmd_t;

	typedef struct packed {
		logic    in_fire;
		action_t act;
		logic    out_free;
		logic    sweep_last;
		logic    n_over;
		logic    n_zero;
		logic    rs_bad;
		logic    rs_at_n;
		logic    p_end;
		logic    nl_bad;
		logic    scan_last;
		logic    k_last;
		logic    mark_hit;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/wpgc_in_if.sv =====
`default_nettype none
interface wpgc_in_if import wpgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [IDX_W-1:0] index;
	logic [VAL_W-1:0] value;

	modport source (output valid, output action, output index, output value, input ready);
	modport sink (input valid, input action, input index, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/wpgc_out_if.sv =====
`default_nettype none
interface wpgc_out_if import wpgc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [BYTE_W-1:0] vertex;
	logic [BYTE_W-1:0] color;
	logic [CNT_W-1:0]  colors_used;
	logic              bad_graph;

	modport source (output valid, output result_kind, output vertex, output color,
		output colors_used, output bad_graph, input ready);
	modport sink (input valid, input result_kind, input vertex, input color,
		input colors_used, input bad_graph, output ready);
endinterface
`default_nettype wire

// ===== rtl/wpgc_cfg_if.sv =====
`default_nettype none
interface wpgc_cfg_if import wpgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wpgc_ram.sv =====
`default_nettype none
module wpgc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/wpgc_ctrl.sv =====
`default_nettype none
module wpgc_ctrl import wpgc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t st,
	output cmd_t         cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (st.in_fire && st.act == ACT_START) begin
					state_d = S_SWEEP;
				end else if (st.in_fire && st.act == ACT_READ) begin
					state_d = S_RD_RESP;
				end
			end
			S_RD_RESP: if (st.out_free) state_d = S_IDLE;
			S_SWEEP: begin
				if (st.sweep_last) state_d = st.n_over ? S_BAD : S_CHK_RD;
			end
			S_CHK_RD: state_d = S_CHK_CK;
			S_CHK_CK: begin
				priority if (st.rs_bad) state_d = S_BAD;
				else if (st.rs_at_n) state_d = S_NL_RD;
				else state_d = S_CHK_RD;
			end
			S_NL_RD: begin
				if (!st.p_end) state_d = S_NL_CK;
				else state_d = st.n_zero ? S_REPORT : S_SCAN_RD;
			end
			S_NL_CK: state_d = st.nl_bad ? S_BAD : S_NL_RD;
			S_SCAN_RD: state_d = S_SCAN_CK;
			S_SCAN_CK: state_d = st.scan_last ? S_PICK : S_SCAN_RD;
			S_PICK: state_d = st.k_last ? S_COL_VO : S_SCAN_RD;
			S_COL_VO: state_d = S_COL_U;
			S_COL_U: state_d = S_COL_LO;
			S_COL_LO: state_d = S_COL_HI;
			S_COL_HI: state_d = S_NB_RD;
			S_NB_RD: state_d = st.p_end ? S_SR_RD : S_NB_CL;
			S_NB_CL: state_d = S_NB_MK;
			S_NB_MK: state_d = S_NB_RD;
			S_SR_RD: state_d = S_SR_CK;
			S_SR_CK: state_d = st.mark_hit ? S_SR_RD : S_ASSIGN;
			S_ASSIGN: state_d = st.k_last ? S_REPORT : S_COL_VO;
			S_BAD: state_d = S_REPORT;
			S_REPORT: if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.in_ready = 1'b1;
			S_RD_RESP: cmd.rd_resp = 1'b1;
			S_SWEEP: cmd.sweep = 1'b1;
			S_CHK_RD: cmd.rs_rd = 1'b1;
			S_CHK_CK: cmd.rs_ck = 1'b1;
			S_NL_RD: begin
				cmd.nl_rd = 1'b1;
				cmd.sort_init = st.p_end && !st.n_zero;
			end
			S_NL_CK: cmd.nl_ck = 1'b1;
			S_SCAN_RD: cmd.scan_rd = 1'b1;
			S_SCAN_CK: cmd.scan_ck = 1'b1;
			S_PICK: begin
				cmd.pick = 1'b1;
				cmd.col_init = st.k_last;
			end
			S_COL_VO: cmd.vo_rd = 1'b1;
			S_COL_U: cmd.u_rd = 1'b1;
			S_COL_LO: cmd.lo_rd = 1'b1;
			S_COL_HI: cmd.hi_cap = 1'b1;
			S_NB_RD: begin
				cmd.nl_rd = 1'b1;
				cmd.sr_init = st.p_end;
			end
			S_NB_CL: cmd.nb_cl = 1'b1;
			S_NB_MK: cmd.nb_mk = 1'b1;
			S_SR_RD: cmd.sr_rd = 1'b1;
			S_SR_CK: cmd.sr_ck = 1'b1;
			S_ASSIGN: cmd.assign_c = 1'b1;
			S_BAD: cmd.bad = 1'b1;
			S_REPORT: cmd.report = 1'b1;
			default: cmd = '0;
		endcase
	end

	// a result is only produced from the two states that own the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPORT && !st.out_free) |=> state_q == S_REPORT)
		else $error("report left before output register was free");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SR_CK && !st.mark_hit) |=> state_q == S_ASSIGN)
		else $error("free color search did not end in assign");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && st.sweep_last && st.n_over) |=> state_q == S_BAD)
		else $error("oversized vertex count not flagged");
endmodule
`default_nettype wire

// ===== rtl/wpgc_dp.sv =====
`default_nettype none
module wpgc_dp import wpgc_pkg::*; #(
	parameter int unsigned MAX_VERTICES = 256,
	parameter int unsigned MAX_EDGES = 2048
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wpgc_in_if.sink     in_ch,
	wpgc_out_if.source  out_ch,
	wpgc_cfg_if.sink    cfg,
	input  wire cmd_t   cmd,
	output status_t     st
);
	localparam int unsigned VW  = $clog2(MAX_VERTICES);
	localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned RSW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned EW  = $clog2(MAX_EDGES);
	localparam int unsigned DW  = VAL_W + 1;

	logic [CNT_W-1:0] vc_q;
	logic             colors_ok_q;
	logic [CNT_W-1:0] last_q;
	logic             out_valid_q;
	logic             kind_q;
	logic [BYTE_W-1:0] vtx_q, col_q;
	logic [CNT_W-1:0] used_q;
	logic             bad_out_q;

	logic [VCW-1:0]   i_q, k_q, most_q;
	logic [VAL_W-1:0] p_q, hi_q, prev_q, best_deg_q;
	logic [VW-1:0]    u_q, c_q, best_q;
	logic             best_vld_q, bad_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_inr_q;

	logic             in_fire;
	action_t          act;
	logic [VCW-1:0]   epoch;

	// memory ports
	logic             rs_we, rs_re;
	logic [RSW-1:0]   rs_waddr, rs_raddr;
	logic [VAL_W-1:0] rs_rdata;
	logic             nl_we, nl_re;
	logic [EW-1:0]    nl_waddr, nl_raddr;
	logic [VAL_W-1:0] nl_rdata;
	logic             dg_we, dg_re;
	logic [VW-1:0]    dg_waddr, dg_raddr;
	logic [DW-1:0]    dg_wdata, dg_rdata;
	logic             vo_we, vo_re;
	logic [VW-1:0]    vo_rdata;
	logic             cl_we, cl_re;
	logic [VW-1:0]    cl_waddr, cl_raddr;
	logic [VW:0]      cl_wdata, cl_rdata;
	logic             mk_we, mk_re;
	logic [VW-1:0]    mk_waddr;
	logic [VCW-1:0]   mk_wdata, mk_rdata;

	logic             rd_unc, out_free;

	assign in_fire = in_ch.valid && cmd.in_ready;
	assign act = action_t'(in_ch.action);
	assign in_ch.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;
	assign epoch = k_q + 1'b1;
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		st = '0;
		st.in_fire = in_fire;
		st.act = act;
		st.out_free = out_free;
		st.sweep_last = 32'(i_q) == MAX_VERTICES - 1;
		st.n_over = 32'(vc_q) > MAX_VERTICES;
		st.n_zero = vc_q == '0;
		st.rs_at_n = 32'(i_q) == 32'(vc_q);
		st.rs_bad = (i_q != '0 && rs_rdata < prev_q)
			|| (st.rs_at_n && 32'(rs_rdata) > MAX_EDGES);
		st.p_end = p_q == hi_q;
		st.nl_bad = nl_rdata >= VAL_W'(vc_q);
		st.scan_last = 32'(i_q) + 1 == 32'(vc_q);
		st.k_last = 32'(k_q) + 1 == 32'(vc_q);
		st.mark_hit = mk_rdata == epoch && 32'(c_q) != MAX_VERTICES - 1;
	end

	// memory port steering
	always_comb begin
		rs_we = in_fire && act == ACT_LOAD_RS && 32'(in_ch.index) < MAX_VERTICES + 1;
		rs_waddr = RSW'(in_ch.index);
		rs_re = cmd.rs_rd || cmd.u_rd || cmd.lo_rd;
		priority if (cmd.u_rd) rs_raddr = RSW'(vo_rdata);
		else if (cmd.lo_rd) rs_raddr = RSW'(u_q) + 1'b1;
		else rs_raddr = RSW'(i_q);

		nl_we = in_fire && act == ACT_LOAD_NL && 32'(in_ch.index) < MAX_EDGES;
		nl_waddr = EW'(in_ch.index);
		nl_re = cmd.nl_rd;
		nl_raddr = EW'(p_q);

		dg_we = (cmd.rs_ck && i_q != '0) || cmd.pick;
		dg_waddr = cmd.pick ? best_q : VW'(i_q - 1'b1);
		dg_wdata = cmd.pick ? {1'b1, best_deg_q} : {1'b0, rs_rdata - prev_q};
		dg_re = cmd.scan_rd;
		dg_raddr = VW'(i_q);

		vo_we = cmd.pick;
		vo_re = cmd.vo_rd;

		cl_we = cmd.sweep || cmd.assign_c;
		cl_waddr = cmd.assign_c ? u_q : VW'(i_q);
		cl_wdata = cmd.assign_c ? {1'b0, c_q} : {1'b1, VW'(0)};
		cl_re = (in_fire && act == ACT_READ) || cmd.nb_cl;
		cl_raddr = cmd.nb_cl ? nl_rdata[VW-1:0] : VW'(in_ch.index);

		mk_we = cmd.sweep || (cmd.nb_mk && !cl_rdata[VW]);
		mk_waddr = cmd.nb_mk ? cl_rdata[VW-1:0] : VW'(i_q);
		mk_wdata = cmd.nb_mk ? epoch : '0;
		mk_re = cmd.sr_rd;
	end

	wpgc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES + 1)) u_row_start (
		.clk, .we(rs_we), .waddr(rs_waddr), .wdata(in_ch.value),
		.re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata));
	wpgc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_EDGES)) u_nbr_list (
		.clk, .we(nl_we), .waddr(nl_waddr), .wdata(in_ch.value),
		.re(nl_re), .raddr(nl_raddr), .rdata(nl_rdata));
	wpgc_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_degree (
		.clk, .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
		.re(dg_re), .raddr(dg_raddr), .rdata(dg_rdata));
	wpgc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_visit (
		.clk, .we(vo_we), .waddr(VW'(k_q)), .wdata(best_q),
		.re(vo_re), .raddr(VW'(k_q)), .rdata(vo_rdata));
	wpgc_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES)) u_color (
		.clk, .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
		.re(cl_re), .raddr(cl_raddr), .rdata(cl_rdata));
	wpgc_ram #(.WIDTH(VCW), .DEPTH(MAX_VERTICES)) u_mark (
		.clk, .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
		.re(mk_re), .raddr(c_q), .rdata(mk_rdata));

	assign rd_unc = !rd_inr_q || !colors_ok_q || cl_rdata[VW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
			colors_ok_q <= 1'b0;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) vc_q <= cfg.data;
			if (cmd.sweep && st.sweep_last) colors_ok_q <= 1'b1;
			if ((cmd.report || cmd.rd_resp) && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (cmd.report && out_free) last_q <= bad_q ? '0 : CNT_W'(most_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && act == ACT_START) begin
			i_q <= '0;
			bad_q <= 1'b0;
			most_q <= '0;
		end
		if (in_fire && act == ACT_READ) begin
			rd_idx_q <= in_ch.index;
			rd_inr_q <= 32'(in_ch.index) < 32'(vc_q) && 32'(in_ch.index) < MAX_VERTICES;
		end
		if (cmd.sweep) i_q <= st.sweep_last ? '0 : i_q + 1'b1;
		if (cmd.rs_ck) begin
			prev_q <= rs_rdata;
			if (i_q == '0) p_q <= rs_rdata;
			if (st.rs_at_n) hi_q <= rs_rdata;
			i_q <= i_q + 1'b1;
		end
		if (cmd.nl_ck || cmd.nb_mk) p_q <= p_q + 1'b1;
		if (cmd.sort_init) begin
			k_q <= '0;
			i_q <= '0;
			best_vld_q <= 1'b0;
		end
		if (cmd.scan_ck) begin
			if (!dg_rdata[VAL_W] && (!best_vld_q || dg_rdata[VAL_W-1:0] > best_deg_q)) begin
				best_q <= VW'(i_q);
				best_deg_q <= dg_rdata[VAL_W-1:0];
				best_vld_q <= 1'b1;
			end
			i_q <= i_q + 1'b1;
		end
		if (cmd.pick) begin
			// last pick restarts the walk for coloring
			k_q <= cmd.col_init ? '0 : k_q + 1'b1;
			i_q <= '0;
			best_vld_q <= 1'b0;
		end
		if (cmd.u_rd) u_q <= vo_rdata;
		if (cmd.lo_rd) p_q <= rs_rdata;
		if (cmd.hi_cap) hi_q <= rs_rdata;
		if (cmd.sr_init) c_q <= '0;
		if (cmd.sr_ck && st.mark_hit) c_q <= c_q + 1'b1;
		if (cmd.assign_c) begin
			if (32'(c_q) + 1 > 32'(most_q)) most_q <= VCW'(c_q) + 1'b1;
			k_q <= k_q + 1'b1;
		end
		if (cmd.bad) bad_q <= 1'b1;
		if (cmd.report && out_free) begin
			kind_q <= KIND_REPORT;
			vtx_q <= '0;
			col_q <= '0;
			used_q <= bad_q ? '0 : CNT_W'(most_q);
			bad_out_q <= bad_q;
		end
		if (cmd.rd_resp && out_free) begin
			kind_q <= KIND_READ;
			vtx_q <= rd_idx_q[BYTE_W-1:0];
			col_q <= rd_unc ? '0 : BYTE_W'(cl_rdata[VW-1:0]);
			used_q <= last_q;
			bad_out_q <= rd_unc;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.result_kind = kind_q;
	assign out_ch.vertex = vtx_q;
	assign out_ch.color = col_q;
	assign out_ch.colors_used = used_q;
	assign out_ch.bad_graph = bad_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nb_mk |-> epoch != '0)
		else $error("mark epoch collides with cleared value");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep && st.sweep_last) |=> colors_ok_q)
		else $error("color store not flagged after clearing sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.assign_c |=> most_q != '0)
		else $error("color count still zero after an assignment");
endmodule
`default_nettype wire

// ===== rtl/welsh_powell_greedy_coloring.sv =====
// Welsh-Powell greedy coloring of a compressed sparse row graph held in on-chip
// memories. Load transactions (row offsets, neighbor entries) are taken one per
// cycle and give no result. A read transaction reads the color store and puts
// its answer into the output register once that register is free; no other
// item is taken until then. A start transaction runs the whole job on memories
// with one write and one read port: a sweep over all MAX_VERTICES entries that
// clears colors and marks, a check of the row offsets, a check of every
// neighbor entry, a selection sort by degree, then the coloring of each vertex
// in sorted order. No other item is taken while a start or read runs, but a
// finished result waits in the output register without holding back new
// loads.
`default_nettype none
module welsh_powell_greedy_coloring import wpgc_pkg::*; #(
	parameter int unsigned MAX_VERTICES = 256,
	parameter int unsigned MAX_EDGES = 2048
) (
	input wire logic   clk,
	input wire logic   arst_n,
	wpgc_in_if.sink    in_ch,
	wpgc_out_if.source out_ch,
	wpgc_cfg_if.sink   cfg
);
	// controller to datapath strobes and datapath flags back
	cmd_t    cmd;
	status_t st;

	// sequencer: sweep, check, sort, color, report
	wpgc_ctrl u_ctrl (
		.clk,
		.arst_n,
		.st,
		.cmd
	);

	// memories, counters and the output register
	wpgc_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES)
	) u_dp (
		.clk,
		.arst_n,
		.in_ch,
		.out_ch,
		.cfg,
		.cmd,
		.st
	);
endmodule
`default_nettype wire
